### rtl/aesd_pkg.sv
// AES-128 decrypt core package: transfer payload types, command codes and
// the inverse S-box table. No dependencies.
`default_nettype none
package aesd_pkg;

    typedef enum logic {
        CMD_KEY_WRITE = 1'b0,
        CMD_DECRYPT   = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic [4:0]  key_slot;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } out_item_t;

    localparam int unsigned SLOT_W = 5;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
            8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
            8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
            8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
            8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
            8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
            8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
            8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
            8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
            8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
            8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
            8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
            8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
            8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
            8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
            8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
            8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
            8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
            8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
            8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
            8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
            8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
            8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
            8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
            8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
            8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
            8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
            8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
            8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
            8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
            8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
            8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
            8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
        };
        return t[x];
    endfunction

endpackage
`default_nettype wire

### rtl/aes128_block_decrypt_core.sv
// AES-128 block decrypt core: key half store and byte-serial round datapath.
// Depends on aesd_pkg.
`default_nettype none
// A key-write transfer stores one 64-bit round key half. A decrypt transfer
// has its result offered in the output register once its rounds are done.
// Each round fetches its key high half, then runs a byte-wide pass over the
// 16-byte state (inverse substitution, skipped in the first round, then add
// key); the middle rounds follow with a column-wide inverse mix columns pass,
// and every round but the last with a row-wide inverse shift rows pass. The
// input is stalled while a block is in the rounds, so a new transfer is taken
// only after the previous decrypt has returned to idle. A finished block waits
// in the output register while the next transfer is taken; the last byte of
// that next block's final byte pass holds until the register is free. Key
// entries never written read as whatever the store holds.
module aes128_block_decrypt_core
    import aesd_pkg::*;
#(
    parameter int unsigned INNER_ROUNDS = 9
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    localparam int unsigned SLOTS  = 2 * (INNER_ROUNDS + 2);
    localparam int unsigned RND_W  = $clog2(INNER_ROUNDS + 2);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(INNER_ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BYTE,
        ST_MIX,
        ST_SHIFT
    } state_t;

    state_t            state_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [3:0]        cnt_reg;
    logic [127:0]      st_reg;
    logic [63:0]       key_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [63:0]       store [0:SLOTS-1];
    logic [63:0]       rd_reg;

    logic              in_acc;
    logic [7:0]        top_byte;
    logic [7:0]        sub_byte;
    logic [7:0]        byte_new;
    logic [7:0]        col0;
    logic [7:0]        col1;
    logic [7:0]        col2;
    logic [7:0]        col3;
    logic [31:0]       mix_col;
    logic [31:0]       row_rot;
    logic [SLOT_W-1:0] rd_slot;
    logic              last_byte;
    logic              out_hold;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign last_byte = (state_reg == ST_BYTE) && (rnd_reg == '0) && (cnt_reg == 4'd15);
    assign out_hold  = last_byte && out_valid_reg && out_stall;

    // Byte stream leaves at the top of the state, key byte from the key half.
    assign top_byte = st_reg[127:120];
    assign sub_byte = inv_sub_byte(top_byte);
    assign byte_new = ((rnd_reg == LAST_RND) ? top_byte : sub_byte) ^ key_reg[63:56];

    // High half while fetching, low half during the byte pass.
    assign rd_slot = SLOT_W'({rnd_reg, state_reg == ST_BYTE});

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] a2, a4, a8, r;
        a2 = xtime(a);
        a4 = xtime(a2);
        a8 = xtime(a4);
        r  = (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00)
           ^ (m[2] ? a4 : 8'h00) ^ (m[3] ? a8 : 8'h00);
        return r;
    endfunction

    // Column under work is column 0: bytes 0, 4, 8 and 12.
    assign col0 = st_reg[127:120];
    assign col1 = st_reg[95:88];
    assign col2 = st_reg[63:56];
    assign col3 = st_reg[31:24];
    assign mix_col[31:24] = gm(col0, 4'd14) ^ gm(col1, 4'd11) ^ gm(col2, 4'd13) ^ gm(col3, 4'd9);
    assign mix_col[23:16] = gm(col0, 4'd9)  ^ gm(col1, 4'd14) ^ gm(col2, 4'd11) ^ gm(col3, 4'd13);
    assign mix_col[15:8]  = gm(col0, 4'd13) ^ gm(col1, 4'd9)  ^ gm(col2, 4'd14) ^ gm(col3, 4'd11);
    assign mix_col[7:0]   = gm(col0, 4'd11) ^ gm(col1, 4'd13) ^ gm(col2, 4'd9)  ^ gm(col3, 4'd14);

    // Row under work is the top row; rotate it right by its row number.
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0: row_rot = st_reg[127:96];
            2'd1: row_rot = {st_reg[103:96], st_reg[127:104]};
            2'd2: row_rot = {st_reg[111:96], st_reg[127:112]};
            2'd3: row_rot = {st_reg[119:96], st_reg[127:120]};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.command == CMD_KEY_WRITE && in_data.key_slot < SLOT_W'(SLOTS))
        begin
            store[in_data.key_slot] <= in_data.data_high;
        end
        rd_reg <= store[rd_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            rnd_reg       <= '0;
            cnt_reg       <= '0;
            st_reg        <= '0;
            key_reg       <= '0;
        end
        else
        begin
            if (last_byte && !out_hold)
            begin
                out_reg       <= {st_reg[119:0], byte_new};
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_data.command == CMD_DECRYPT)
                    begin
                        st_reg    <= {in_data.data_high, in_data.data_low};
                        rnd_reg   <= LAST_RND;
                        cnt_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (cnt_reg == 4'd1)
                    begin
                        key_reg   <= rd_reg;
                        cnt_reg   <= '0;
                        state_reg <= ST_BYTE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_BYTE:
                begin
                    if (!out_hold)
                    begin
                        st_reg  <= {st_reg[119:0], byte_new};
                        cnt_reg <= cnt_reg + 4'd1;
                        if (cnt_reg == 4'd7)
                        begin
                            key_reg <= rd_reg;
                        end
                        else
                        begin
                            key_reg <= {key_reg[55:0], 8'h00};
                        end
                        if (cnt_reg == 4'd15)
                        begin
                            if (rnd_reg == '0)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else if (rnd_reg == LAST_RND)
                            begin
                                state_reg <= ST_SHIFT;
                            end
                            else
                            begin
                                state_reg <= ST_MIX;
                            end
                        end
                    end
                end
                ST_MIX:
                begin
                    st_reg <= {st_reg[119:96], mix_col[31:24],
                               st_reg[87:64],  mix_col[23:16],
                               st_reg[55:32],  mix_col[15:8],
                               st_reg[23:0],   mix_col[7:0]};
                    if (cnt_reg == 4'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_SHIFT:
                begin
                    st_reg <= {st_reg[95:0], row_rot};
                    if (cnt_reg == 4'd3)
                    begin
                        cnt_reg   <= '0;
                        rnd_reg   <= rnd_reg - RND_W'(1);
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("transfer taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("result dropped under stall");
`endif

endmodule
`default_nettype wire

### verif/aes128_block_decrypt_core_tb.sv
// Testbench for aes128_block_decrypt_core: key half writes and block decrypts
// are checked against an in-bench AES-128 inverse cipher with its own key store.
// Depends on aesd_pkg and the core RTL.
`default_nettype none
module aes128_block_decrypt_core_tb
    import aesd_pkg::*;
();

    localparam int KEY_DEPTH  = 22;
    localparam int LAST_ROUND = 10;
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 900;
    localparam int RANDOM_ITEMS = 1400;

    class plaintext_board;
        logic [63:0] key_half [KEY_DEPTH];
        logic [7:0]  inv_box [256];
        out_item_t   plain_q [$];
        int          mismatches;

        function new();
            logic [7:0] b;
            logic [7:0] s;
            for (int x = 0; x < 256; x++)
            begin
                b = 8'h00;
                for (int y = 1; y < 256; y++)
                    if (x != 0 && gmul(x[7:0], y[7:0]) == 8'h01)
                        b = y[7:0];
                s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
                inv_box[s] = x[7:0];
            end
            mismatches = 0;
        endfunction

        function logic [7:0] gmul(logic [7:0] a, logic [7:0] m);
            logic [7:0] acc;
            acc = 8'h00;
            for (int i = 0; i < 8; i++)
            begin
                if (m[i])
                    acc ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return acc;
        endfunction

        function void xor_round_key(ref logic [7:0] st [16], input int rnd);
            for (int i = 0; i < 8; i++)
            begin
                st[i]     ^= key_half[2*rnd][63-8*i -: 8];
                st[8 + i] ^= key_half[2*rnd+1][63-8*i -: 8];
            end
        endfunction

        function void unshift_unsub(ref logic [7:0] st [16]);
            logic [7:0] t [16];
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[4*r + ((c + r) & 3)] = st[4*r + c];
            for (int i = 0; i < 16; i++)
                st[i] = inv_box[t[i]];
        endfunction

        function void unmix(ref logic [7:0] st [16]);
            logic [7:0] coef [4];
            logic [7:0] t [16];
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                begin
                    t[4*r + c] = 8'h00;
                    for (int k = 0; k < 4; k++)
                        t[4*r + c] ^= gmul(coef[(k + 4 - r) & 3], st[4*k + c]);
                end
            st = t;
        endfunction

        function void note_transfer(in_item_t it);
            logic [7:0] st [16];
            out_item_t  res;
            if (it.command == CMD_KEY_WRITE)
            begin
                if (it.key_slot < KEY_DEPTH)
                    key_half[it.key_slot] = it.data_high;
                return;
            end
            for (int i = 0; i < 8; i++)
            begin
                st[i]     = it.data_high[63-8*i -: 8];
                st[8 + i] = it.data_low[63-8*i -: 8];
            end
            xor_round_key(st, LAST_ROUND);
            unshift_unsub(st);
            for (int rnd = LAST_ROUND - 1; rnd >= 1; rnd--)
            begin
                xor_round_key(st, rnd);
                unmix(st);
                unshift_unsub(st);
            end
            xor_round_key(st, 0);
            for (int i = 0; i < 8; i++)
            begin
                res.plain_high[63-8*i -: 8] = st[i];
                res.plain_low[63-8*i -: 8]  = st[8 + i];
            end
            plain_q.push_back(res);
        endfunction

        function void check_plaintext(out_item_t got);
            out_item_t want;
            if (plain_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected plaintext %h_%h", got.plain_high, got.plain_low);
                return;
            end
            want = plain_q.pop_front();
            if (got.plain_high !== want.plain_high || got.plain_low !== want.plain_low)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("plaintext mismatch: expected %h_%h actual %h_%h",
                             want.plain_high, want.plain_low,
                             got.plain_high, got.plain_low);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    plaintext_board board;
    int  idle_cycles;
    bit  calm_in;
    bit  calm_out;
    bit  hold_req;

    aes128_block_decrypt_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        board.note_transfer(it);
        @(negedge clk);
    endtask

    task automatic send_key(int slot, logic [63:0] half);
        in_item_t it;
        it.command   = CMD_KEY_WRITE;
        it.key_slot  = slot[4:0];
        it.data_high = half;
        it.data_low  = rand64();
        send_item(it);
    endtask

    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        in_item_t it;
        it.command   = CMD_DECRYPT;
        it.key_slot  = 5'($urandom_range(0, 31));
        it.data_high = hi;
        it.data_low  = lo;
        send_item(it);
    endtask

    // receiver: random hold-off per transfer, one long hold-off on request
    initial
    begin
        int w;
        out_stall <= 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            w = calm_out ? 0 : $urandom_range(0, 5);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_plaintext(out_data);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        board       = new();
        idle_cycles = 0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: fill every key slot, try slots past the store, extreme blocks
        send_key(0, 64'h0);
        for (int s = 1; s < KEY_DEPTH - 1; s++)
            send_key(s, rand64());
        send_key(KEY_DEPTH - 1, '1);
        send_key(KEY_DEPTH, rand64());
        send_key(31, rand64());
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);

        // random: mostly decrypts under fresh keys, some rekeying and stray slots
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 200 == 0)
                calm_in = ($urandom_range(0, 2) == 0);
            if (n % 150 == 0)
                calm_out = ($urandom_range(0, 2) == 0);
            if (n == 300)
            begin
                calm_in  = 1'b1;
                hold_req = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: send_key($urandom_range(0, KEY_DEPTH - 1), rand64());
                3:       send_key($urandom_range(KEY_DEPTH, 31), rand64());
                default: send_block(rand64(), rand64());
            endcase
        end
        in_valid <= 1'b0;

        while (board.plain_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
